### rtl/gclf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclf_pkg
// Types, opcode constants and length decode for the layout command framer.
// ----------------------------------------------------------------------------
package gclf_pkg;

  localparam int unsigned OffsetBitsDefault = 24;
  localparam int unsigned OffsetOutBits     = 24;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_TRUNC = 2'd2
  } item_kind_e;

  // Opcodes with special handling
  localparam logic [7:0] OP_END      = 8'h01;
  localparam logic [7:0] OP_RETURN   = 8'h03;
  localparam logic [7:0] OP_OPEN_A   = 8'h04;
  localparam logic [7:0] OP_CLOSE    = 8'h05;
  localparam logic [7:0] OP_OPEN_B   = 8'h08;
  localparam logic [7:0] OP_ARG_LEN  = 8'h0A;
  localparam logic [7:0] OP_SUBLAY   = 8'h10;
  localparam logic [7:0] OP_EXT_A    = 8'h11;
  localparam logic [7:0] OP_EXT_B    = 8'h12;
  localparam logic [7:0] OP_EXT_C    = 8'h14;
  localparam logic [7:0] OP_OPEN_C   = 8'h16;
  localparam logic [7:0] OP_EXT_D    = 8'h1D;
  localparam logic [7:0] OP_OPEN_D   = 8'h20;
  localparam logic [7:0] OP_MAX_KNOWN = 8'h20;

  localparam logic [4:0] LEN_TABLE [0:32] = '{
    5'd8,  5'd4, 5'd8, 5'd4,  5'd4, 5'd4, 5'd4, 5'd4,
    5'd12, 5'd4, 5'd8, 5'd4,  5'd4, 5'd8, 5'd8, 5'd20,
    5'd16, 5'd8, 5'd8, 5'd12, 5'd8, 5'd8, 5'd8, 5'd4,
    5'd8,  5'd8, 5'd8, 5'd4,  5'd12, 5'd8, 5'd8, 5'd16,
    5'd4
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_region;
  } in_word_t;

  typedef struct packed {
    item_kind_e  item_kind;
    logic [7:0]  opcode;
    logic [7:0]  arg_byte;
    logic [4:0]  length;
    logic [23:0] offset;
    logic [7:0]  depth;
    logic        starts_layout;
    logic        unknown_op;
    logic [31:0] word_one;
    logic [31:0] word_two;
  } out_word_t;

  function automatic logic [4:0] decode_len(logic [7:0] op, logic [7:0] arg);
    logic [4:0] len;
    begin
      if (op > OP_MAX_KNOWN) begin
        len = 5'd4;
      end else begin
        len = LEN_TABLE[op[5:0]];
        case (op)
          OP_ARG_LEN: begin
            if (arg != 8'd0) len = len + 5'd4;
          end
          OP_SUBLAY: begin
            case (arg[6:4])
              3'd0:    len = 5'd16;
              3'd1:    len = 5'd8;
              3'd2:    len = 5'd8;
              3'd3:    len = 5'd4;
              default: len = len;
            endcase
            if (arg[7]) len = len + 5'd4;
          end
          OP_EXT_A, OP_EXT_B, OP_EXT_C, OP_EXT_D: begin
            if (arg[7]) len = len + 5'd4;
          end
          default: len = len;
        endcase
      end
      return len;
    end
  endfunction

endpackage

### rtl/geo_layout_command_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_layout_command_framer_unit
// Cuts a layout command script, one byte per word, into commands, padding
// words and truncated commands, one result word per finished item.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the output is not stalled, set by the combinational decode/update path.
// Latency: a result is valid the cycle after the byte that finishes it.
// The output register frees in the same cycle it is taken, so input stalls
// only while a result waits on out_ready_i.
// Reset: start offset 0, framer at start of region, depth 1, no result held.
// A config write restarts the framer at the new start offset.
module geo_layout_command_framer_unit #(
  parameter int unsigned OFFSET_BITS = gclf_pkg::OffsetBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gclf_pkg::in_word_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gclf_pkg::out_word_t out_data_o
);
  import gclf_pkg::*;

  logic [23:0]            start_offset_q;
  logic [OFFSET_BITS-1:0] position_q, position_d;
  logic [OFFSET_BITS-1:0] cmd_start_q, cmd_start_d;
  logic [4:0]             bytes_seen_q, bytes_seen_d;
  logic [7:0]             cur_opcode_q, cur_opcode_d;
  logic [7:0]             cur_arg_q, cur_arg_d;
  logic [31:0]            word_one_q, word_one_d;
  logic [31:0]            word_two_q, word_two_d;
  logic [7:0]             nest_q, nest_d;
  logic                   new_layout_q, new_layout_d;
  logic                   padding_q, padding_d;
  logic                   all_zero_q, all_zero_d;

  logic                   out_valid_q;
  out_word_t              out_q, res;
  logic                   emit;

  logic                   in_fire;
  logic [OFFSET_BITS-1:0] pos_init;
  logic [31:0]            start_ext;
  logic [31:0]            cs_ext;
  logic [7:0]             b;
  logic [4:0]             idx, seen_inc, len_n;
  logic                   padded, pad_exit, finish, is_close, is_end;
  logic                   is_open;
  logic [7:0]             nest_listed;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign start_ext = {8'd0, start_offset_q};
  assign pos_init  = start_ext[OFFSET_BITS-1:0];
  assign b         = in_data_i.data_byte;
  assign idx       = bytes_seen_q;

  always_comb begin
    cmd_start_d  = (idx == 5'd0) ? position_q : cmd_start_q;
    cur_opcode_d = (idx == 5'd0) ? b : cur_opcode_q;
    cur_arg_d    = (idx == 5'd0) ? 8'd0 : ((idx == 5'd1) ? b : cur_arg_q);
    word_one_d   = (idx == 5'd0) ? 32'd0 : word_one_q;
    word_two_d   = (idx == 5'd0) ? 32'd0 : word_two_q;
    // big-endian lane: byte index 4 lands in the top byte
    for (int k = 0; k < 4; k++) begin
      if (idx[4:2] == 3'b001 && idx[1:0] == 2'(3 - k)) word_one_d[8*k +: 8] = b;
      if (idx[4:2] == 3'b010 && idx[1:0] == 2'(3 - k)) word_two_d[8*k +: 8] = b;
    end
    if (idx == 5'd0)             all_zero_d = (b == 8'd0);
    else if (idx[4:2] == 3'b000) all_zero_d = all_zero_q && (b == 8'd0);
    else                         all_zero_d = all_zero_q;

    seen_inc   = (idx < 5'd31) ? idx + 5'd1 : idx;
    len_n      = decode_len(cur_opcode_d, cur_arg_d);
    position_d = position_q + OFFSET_BITS'(1);

    padded   = padding_q && (seen_inc == 5'd4) && all_zero_d;
    pad_exit = padding_q && (seen_inc == 5'd4) && !all_zero_d;
    finish   = !padded && (seen_inc >= len_n);

    is_close = (cur_opcode_d == OP_END) || (cur_opcode_d == OP_CLOSE);
    is_end   = (cur_opcode_d == OP_END) || (cur_opcode_d == OP_RETURN);
    is_open  = (cur_opcode_d == OP_OPEN_A) || (cur_opcode_d == OP_OPEN_B) ||
               (cur_opcode_d == OP_OPEN_C) || (cur_opcode_d == OP_OPEN_D);

    nest_listed  = (finish && is_close && nest_q > 8'd1) ? nest_q - 8'd1 : nest_q;
    nest_d       = nest_listed;
    new_layout_d = new_layout_q;
    padding_d    = padding_q && !pad_exit;
    bytes_seen_d = (padded || finish) ? 5'd0 : seen_inc;
    if (finish) begin
      new_layout_d = 1'b0;
      if (is_open && nest_listed != 8'hFF) nest_d = nest_listed + 8'd1;
      if (is_end) begin
        nest_d       = 8'd1;
        new_layout_d = 1'b1;
        padding_d    = 1'b1;
      end
    end

    cs_ext = 32'(cmd_start_d);
    res.offset        = cs_ext[OffsetOutBits-1:0];
    res.item_kind     = KIND_CMD;
    res.opcode        = cur_opcode_d;
    res.arg_byte      = cur_arg_d;
    res.length        = len_n;
    res.depth         = nest_listed;
    res.starts_layout = new_layout_q;
    res.word_one      = word_one_d;
    res.word_two      = word_two_d;
    emit = 1'b1;
    if (padded) begin
      res.item_kind     = KIND_PAD;
      res.opcode        = 8'd0;
      res.arg_byte      = 8'd0;
      res.length        = 5'd4;
      res.depth         = nest_q;
      res.starts_layout = 1'b0;
      res.word_one      = 32'd0;
      res.word_two      = 32'd0;
    end else if (!finish) begin
      // truncated only when the region ends mid-item
      res.item_kind = KIND_TRUNC;
      emit = in_data_i.end_of_region && (seen_inc != 5'd0);
    end
    res.unknown_op = (res.opcode > OP_MAX_KNOWN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= 24'd0;
      position_q     <= '0;
      cmd_start_q    <= '0;
      bytes_seen_q   <= 5'd0;
      cur_opcode_q   <= 8'd0;
      cur_arg_q      <= 8'd0;
      word_one_q     <= 32'd0;
      word_two_q     <= 32'd0;
      nest_q         <= 8'd1;
      new_layout_q   <= 1'b1;
      padding_q      <= 1'b0;
      all_zero_q     <= 1'b1;
    end else if (cfg_we_i) begin
      start_offset_q <= cfg_wdata_i;
      position_q     <= OFFSET_BITS'({8'd0, cfg_wdata_i});
      cmd_start_q    <= OFFSET_BITS'({8'd0, cfg_wdata_i});
      bytes_seen_q   <= 5'd0;
      cur_opcode_q   <= 8'd0;
      cur_arg_q      <= 8'd0;
      word_one_q     <= 32'd0;
      word_two_q     <= 32'd0;
      nest_q         <= 8'd1;
      new_layout_q   <= 1'b1;
      padding_q      <= 1'b0;
      all_zero_q     <= 1'b1;
    end else if (in_fire) begin
      if (in_data_i.end_of_region) begin
        position_q   <= pos_init;
        cmd_start_q  <= pos_init;
        bytes_seen_q <= 5'd0;
        cur_opcode_q <= 8'd0;
        cur_arg_q    <= 8'd0;
        word_one_q   <= 32'd0;
        word_two_q   <= 32'd0;
        nest_q       <= 8'd1;
        new_layout_q <= 1'b1;
        padding_q    <= 1'b0;
        all_zero_q   <= 1'b1;
      end else begin
        position_q   <= position_d;
        cmd_start_q  <= cmd_start_d;
        bytes_seen_q <= bytes_seen_d;
        cur_opcode_q <= cur_opcode_d;
        cur_arg_q    <= cur_arg_d;
        word_one_q   <= word_one_d;
        word_two_q   <= word_two_d;
        nest_q       <= nest_d;
        new_layout_q <= new_layout_d;
        padding_q    <= padding_d;
        all_zero_q   <= all_zero_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Depth never drops to zero
  a_nest_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nest_q != 8'd0) else $error("nesting level reached zero");

  // End of region returns the framer to the start of a command
  a_eor_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_region && !cfg_we_i |=>
      bytes_seen_q == 5'd0 && !padding_q && new_layout_q && nest_q == 8'd1)
    else $error("framer not restarted after end of region");

  // Padding words carry fixed header fields
  a_pad_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.item_kind == KIND_PAD |->
      out_q.opcode == 8'd0 && out_q.length == 5'd4 && !out_q.starts_layout)
    else $error("malformed padding word");

  // A byte is only refused while a result is held
  a_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled without a pending result");

endmodule

### test/tb_geo_layout_command_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_geo_layout_command_framer_unit
// Streams layout scripts into the framer byte by byte and compares every
// result word with a cycle-free model of the command cutter kept below.
// Directed words first, then random scripts, noise and a deep nesting run.
// ----------------------------------------------------------------------------
module tb_geo_layout_command_framer_unit;
  import gclf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;

  // Base command length per known opcode, before argument adjustments
  localparam logic [4:0] BASE_SPAN [0:32] = '{
    5'd8,  5'd4, 5'd8, 5'd4,  5'd4, 5'd4, 5'd4, 5'd4,
    5'd12, 5'd4, 5'd8, 5'd4,  5'd4, 5'd8, 5'd8, 5'd20,
    5'd16, 5'd8, 5'd8, 5'd12, 5'd8, 5'd8, 5'd8, 5'd4,
    5'd8,  5'd8, 5'd8, 5'd4,  5'd12, 5'd8, 5'd8, 5'd16,
    5'd4
  };

  class command_frame_tracker;
    out_word_t   pending_words[$];
    logic [23:0] region_base;
    logic [23:0] cursor;
    logic [23:0] item_base;
    int unsigned seen;
    logic [4:0]  span;
    logic [7:0]  head_op;
    logic [7:0]  head_arg;
    logic [31:0] tail_one;
    logic [31:0] tail_two;
    logic [7:0]  level;
    bit          fresh_layout;
    bit          in_padding;
    bit          head_zero;
    int unsigned mismatches, checked, cmds, pads, truncs, deepest;

    function new();
      region_base = '0;
      mismatches = 0;
      checked = 0;
      cmds = 0;
      pads = 0;
      truncs = 0;
      deepest = 1;
      rewind();
    endfunction

    function void rewind();
      cursor = region_base;
      item_base = region_base;
      seen = 0;
      span = 5'd4;
      head_op = '0;
      head_arg = '0;
      tail_one = '0;
      tail_two = '0;
      level = 8'd1;
      fresh_layout = 1'b1;
      in_padding = 1'b0;
      head_zero = 1'b1;
    endfunction

    function void set_base(logic [23:0] base);
      region_base = base;
      rewind();
    endfunction

    function logic [4:0] span_of(logic [7:0] op, logic [7:0] arg);
      logic [4:0] n;
      n = 5'd4;
      if (op <= OP_MAX_KNOWN) begin
        n = BASE_SPAN[op[5:0]];
        if (op == OP_ARG_LEN) begin
          if (arg != 8'd0) n = n + 5'd4;
        end else if (op == OP_SUBLAY) begin
          case (arg[6:4])
            3'd0:       n = 5'd16;
            3'd1, 3'd2: n = 5'd8;
            3'd3:       n = 5'd4;
            default:    ;
          endcase
          if (arg[7]) n = n + 5'd4;
        end else if (op == OP_EXT_A || op == OP_EXT_B || op == OP_EXT_C ||
                     op == OP_EXT_D) begin
          if (arg[7]) n = n + 5'd4;
        end
      end
      return n;
    endfunction

    function out_word_t build(item_kind_e kind, logic [7:0] op, logic [7:0] arg,
                              logic [4:0] len, bit starts, logic [31:0] w1,
                              logic [31:0] w2);
      out_word_t w;
      w.item_kind     = kind;
      w.opcode        = op;
      w.arg_byte      = arg;
      w.length        = len;
      w.offset        = item_base;
      w.depth         = level;
      w.starts_layout = starts;
      w.unknown_op    = (op > OP_MAX_KNOWN);
      w.word_one      = w1;
      w.word_two      = w2;
      return w;
    endfunction

    // Advance the cutter by one accepted byte; queue the result it yields
    function void take_byte(in_word_t w);
      out_word_t   want;
      bit          made;
      bit          padded;
      int unsigned idx;
      logic [7:0]  b;
      b = w.data_byte;
      idx = seen;
      made = 1'b0;
      padded = 1'b0;
      want = '0;
      if (idx == 0) begin
        item_base = cursor;
        head_op = b;
        head_arg = '0;
        tail_one = '0;
        tail_two = '0;
        head_zero = 1'b1;
      end else if (idx == 1) begin
        head_arg = b;
      end
      if (idx < 4) begin
        if (b != 8'd0) head_zero = 1'b0;
      end else if (idx < 8) begin
        tail_one[8*(7-idx) +: 8] = b;
      end else if (idx < 12) begin
        tail_two[8*(11-idx) +: 8] = b;
      end
      if (seen < 31) seen++;
      span = span_of(head_op, head_arg);
      cursor = cursor + 24'd1;

      if (in_padding && seen == 4) begin
        if (head_zero) begin
          want = build(KIND_PAD, 8'd0, 8'd0, 5'd4, 1'b0, 32'd0, 32'd0);
          made = 1'b1;
          padded = 1'b1;
          seen = 0;
          pads++;
        end else begin
          in_padding = 1'b0;
        end
      end

      if (!padded && seen >= span) begin
        if ((head_op == OP_END || head_op == OP_CLOSE) && level > 8'd1) level--;
        want = build(KIND_CMD, head_op, head_arg, span, fresh_layout, tail_one,
                     tail_two);
        made = 1'b1;
        cmds++;
        fresh_layout = 1'b0;
        if (head_op == OP_OPEN_A || head_op == OP_OPEN_B || head_op == OP_OPEN_C ||
            head_op == OP_OPEN_D) begin
          if (level < 8'd255) level++;
          if (level > deepest) deepest = level;
        end
        if (head_op == OP_END || head_op == OP_RETURN) begin
          level = 8'd1;
          fresh_layout = 1'b1;
          in_padding = 1'b1;
        end
        seen = 0;
      end

      if (w.end_of_region) begin
        if (!made && seen > 0) begin
          want = build(KIND_TRUNC, head_op, head_arg, span, fresh_layout, tail_one,
                       tail_two);
          made = 1'b1;
          truncs++;
        end
        rewind();
      end
      if (made) pending_words.push_back(want);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
               want);
    endtask

    task match_word(out_word_t got);
      out_word_t want;
      if (pending_words.size() == 0) begin
        report("word with nothing expected", 32'(got.opcode), 32'd0);
        return;
      end
      want = pending_words.pop_front();
      checked++;
      if (got.item_kind !== want.item_kind)
        report("item_kind", 32'(got.item_kind), 32'(want.item_kind));
      if (got.opcode !== want.opcode)
        report("opcode", 32'(got.opcode), 32'(want.opcode));
      if (got.arg_byte !== want.arg_byte)
        report("arg_byte", 32'(got.arg_byte), 32'(want.arg_byte));
      if (got.length !== want.length)
        report("length", 32'(got.length), 32'(want.length));
      if (got.offset !== want.offset)
        report("offset", 32'(got.offset), 32'(want.offset));
      if (got.depth !== want.depth)
        report("depth", 32'(got.depth), 32'(want.depth));
      if (got.starts_layout !== want.starts_layout)
        report("starts_layout", 32'(got.starts_layout), 32'(want.starts_layout));
      if (got.unknown_op !== want.unknown_op)
        report("unknown_op", 32'(got.unknown_op), 32'(want.unknown_op));
      if (got.word_one !== want.word_one) report("word_one", got.word_one, want.word_one);
      if (got.word_two !== want.word_two) report("word_two", got.word_two, want.word_two);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;

  command_frame_tracker tracker = new();

  bit          calm = 1'b0;     // no idling on either side
  bit          idle_on = 1'b1;  // sender gaps allowed in this region
  int unsigned bytes_sent = 0;
  int unsigned cfg_writes = 0;

  geo_layout_command_framer_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_geo_layout_command_framer_unit failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.match_word(out_word);
  end

  // Receiver: stall bursts, switched off in some windows and in the calm tail
  initial begin
    int unsigned hold;
    int unsigned window;
    bit          stall_on;
    window = 0;
    stall_on = 1'b1;
    @(posedge rst_n);
    forever begin
      if (window == 0) begin
        window = 64;
        stall_on = ($urandom_range(0, 3) != 0);
      end
      window--;
      hold = 0;
      if (!calm && stall_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 8);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [7:0] fill_byte();
    if ($urandom_range(0, 3) == 0) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    case ($urandom_range(0, 9))
      0: op = OP_END;
      1: op = OP_RETURN;
      2: op = OP_CLOSE;
      3: begin
        case ($urandom_range(0, 3))
          0:       op = OP_OPEN_A;
          1:       op = OP_OPEN_B;
          2:       op = OP_OPEN_C;
          default: op = OP_OPEN_D;
        endcase
      end
      4: op = 8'($urandom_range(OP_MAX_KNOWN + 1, 255));
      default: op = 8'($urandom_range(0, OP_MAX_KNOWN));
    endcase
    return op;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit eor);
    int unsigned gap;
    gap = 0;
    if (!calm && idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{data_byte: b, end_of_region: eor};
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(in_word);
    bytes_sent++;
  endtask

  task automatic send_command(input logic [7:0] op, input logic [7:0] arg,
                              input int unsigned count, input bit eor_last);
    logic [7:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 0) b = op;
      else if (i == 1) b = arg;
      else b = fill_byte();
      send_byte(b, eor_last && (i == count - 1));
    end
  endtask

  task automatic send_zeros(input int unsigned count, input bit eor_last);
    for (int unsigned i = 0; i < count; i++) send_byte(8'd0, eor_last && (i == count - 1));
  endtask

  // Sender stops; wait for every queued result, then for the pipe to settle
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_start(input logic [23:0] base);
    hold_until_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    tracker.set_base(base);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  // Well-formed script of whole commands; optionally cut short at the end
  task automatic send_script(input int unsigned n_cmds, input bit cut);
    logic [7:0]  op;
    logic [7:0]  arg;
    int unsigned len;
    bit          last;
    for (int unsigned c = 0; c < n_cmds; c++) begin
      last = (c == n_cmds - 1);
      op = pick_opcode();
      arg = fill_byte();
      len = tracker.span_of(op, arg);
      if (last && cut) begin
        if (op == OP_END || op == OP_RETURN) begin
          // region ends inside (or exactly on) a padding word
          send_command(op, arg, len, 1'b0);
          send_zeros($urandom_range(1, 4), 1'b1);
        end else begin
          send_command(op, arg, $urandom_range(1, len - 1), 1'b1);
        end
      end else begin
        send_command(op, arg, len, last);
        if (!last && (op == OP_END || op == OP_RETURN))
          send_zeros(4 * $urandom_range(0, 3), 1'b0);
      end
    end
  endtask

  initial begin
    logic [23:0] bases [6];
    int unsigned goal;
    int unsigned n;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: open, end, padding word, unknown opcode, truncations
    send_command(OP_OPEN_A, 8'hFF, 4, 1'b0);
    send_command(OP_END, 8'h00, 4, 1'b0);
    send_zeros(4, 1'b0);
    send_command(8'hFF, 8'h00, 4, 1'b0);
    send_command(OP_ARG_LEN, 8'h01, 3, 1'b1);
    send_byte(OP_SUBLAY, 1'b1);              // argument never arrives
    send_byte(8'hFF, 1'b1);

    bases[0] = 24'hFFFFFF;
    bases[1] = 24'hFFFFF8;
    bases[2] = 24'h000000;
    bases[3] = 24'($urandom);
    bases[4] = 24'h000001;
    bases[5] = 24'($urandom);

    for (int unsigned p = 0; p < 6; p++) begin
      load_start(bases[p]);
      if (p == 5) calm = 1'b1;
      if (p == 3) begin
        // deep nesting, then closes and an end
        for (int unsigned i = 0; i < 50; i++)
          send_command((i % 2) ? OP_OPEN_A : OP_OPEN_D, fill_byte(), 4, 1'b0);
        send_command(OP_CLOSE, fill_byte(), 4, 1'b0);
        send_command(OP_CLOSE, fill_byte(), 4, 1'b0);
        send_command(OP_END, fill_byte(), 4, 1'b1);
      end
      goal = bytes_sent + 80;
      while (bytes_sent < goal) begin
        idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 6) == 0) begin
          n = $urandom_range(5, 40);
          for (int unsigned i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)),
                      (i == n - 1) || ($urandom_range(0, 31) == 0));
        end else begin
          send_script($urandom_range(1, 8), $urandom_range(0, 3) == 0);
        end
      end
    end

    hold_until_drained();
    $display("%0d bytes sent, %0d results checked: %0d commands, %0d padding, %0d truncated",
             bytes_sent, tracker.checked, tracker.cmds, tracker.pads, tracker.truncs);
    $display("%0d start offset settings, deepest nesting level %0d",
             cfg_writes, tracker.deepest);
    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
      $display("tb_geo_layout_command_framer_unit passed");
    end else begin
      $display("tb_geo_layout_command_framer_unit failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gclf_pkg.sv
rtl/geo_layout_command_framer_unit.sv
test/tb_geo_layout_command_framer_unit.sv
